### rtl/active_note_tracker_assert.svh
// Assertion macros for the active note tracker.
// Used by the RTL files that carry concurrent checks; no other dependencies.
`ifndef ACTIVE_NOTE_TRACKER_ASSERT_SVH
`define ACTIVE_NOTE_TRACKER_ASSERT_SVH
`ifndef SYNTHESIS
`define ANT_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
`define ANT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`else
`define ANT_ASSERT_SAME(lbl, clk, rst_n, ante, cons)
`define ANT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

### rtl/ant_pkg.sv
// Shared types and codes for the active note tracker.
// No dependencies; used by ant_cell and active_note_tracker.
`default_nettype none
package ant_pkg;
	localparam int TABLE_DEPTH_DEF = 32;
	localparam int CH_W = 8;
	localparam int DA_W = 7;
	localparam int DB_W = 7;

	localparam logic KIND_PLAY  = 1'b0;
	localparam logic KIND_FLUSH = 1'b1;

	localparam logic [1:0] EV_NOTE = 2'd0;
	localparam logic [1:0] EV_CTRL = 2'd1;

	localparam logic OUT_NOTE = 1'b0;
	localparam logic OUT_CTRL = 1'b1;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_REMOVE,
		ST_FLUSH
	} state_t;

	typedef struct packed {
		logic            append;
		logic            compare;
		logic [CH_W-1:0] ch;
		logic [DA_W-1:0] pitch;
	} cell_ctl_t;
endpackage
`default_nettype wire

### rtl/ant_cell.sv
// One entry of the note table: valid flag, channel, pitch and match flag.
// Depends on ant_pkg; instantiated in a row by active_note_tracker.
`default_nettype none
module ant_cell
	import ant_pkg::*;
(
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire cell_ctl_t       ctl,
	input  wire logic            shift,
	input  wire logic            prev_valid,
	input  wire logic            next_valid,
	input  wire logic [CH_W-1:0] next_channel,
	input  wire logic [DA_W-1:0] next_pitch,
	output logic                 valid,
	output logic [CH_W-1:0]      channel,
	output logic [DA_W-1:0]      pitch,
	output logic                 hit
);
	logic            valid_q;
	logic [CH_W-1:0] channel_q;
	logic [DA_W-1:0] pitch_q;
	logic            hit_s1;
	logic            take;

	assign take = ctl.append && prev_valid && !valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			hit_s1  <= 1'b0;
		end else begin
			hit_s1 <= ctl.compare && valid_q && (channel_q == ctl.ch) && (pitch_q == ctl.pitch);
			if (shift) begin
				valid_q <= next_valid;
			end else if (take) begin
				valid_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (shift) begin
			channel_q <= next_channel;
			pitch_q   <= next_pitch;
		end else if (take) begin
			channel_q <= ctl.ch;
			pitch_q   <= ctl.pitch;
		end
	end

	assign valid   = valid_q;
	assign channel = channel_q;
	assign pitch   = pitch_q;
	assign hit     = hit_s1;
endmodule
`default_nettype wire

### rtl/active_note_tracker.sv
// Active note tracker top level: handshake, sequencer and the row of cells.
// Depends on ant_pkg, ant_cell and active_note_tracker_assert.svh.
//
// Usage: drive an event word on kind, event_type, channel, data_a, data_b
// and muted with start high; it is taken at a rising edge where busy is low.
// Results appear on out_type, out_channel, out_data_a, out_data_b, overflow
// and last for exactly one cycle each, marked by out_valid; the receiver
// cannot stall, so every marked cycle delivers one word.
// Latency: a result appears in the cycle after the edge that produced it.
// Controller and note-on words leave busy low and a new word may follow at
// once. A note-off raises busy for ST_REMOVE: the cells compare in parallel
// as it is taken, and in ST_REMOVE the table closes the gap with a one-place
// shift. A flush emits one note-off per stored entry, one per cycle, shifting
// the row towards the head; it holds busy until the last entry is emitted.
// Reset clears every entry's valid flag at once, so the table is empty and
// ready in the first cycle after arst_n rises; there is no clearing pass.
`default_nettype none
`include "active_note_tracker_assert.svh"
module active_note_tracker
	import ant_pkg::*;
#(
	parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            start,
	output logic                 busy,
	input  wire logic            kind,
	input  wire logic [1:0]      event_type,
	input  wire logic [CH_W-1:0] channel,
	input  wire logic [DA_W-1:0] data_a,
	input  wire logic [DB_W-1:0] data_b,
	input  wire logic            muted,
	output logic                 out_valid,
	output logic                 out_type,
	output logic [CH_W-1:0]      out_channel,
	output logic [DA_W-1:0]      out_data_a,
	output logic [DB_W-1:0]      out_data_b,
	output logic                 overflow,
	output logic                 last
);
	localparam logic [TABLE_DEPTH-1:0] ONE = {{(TABLE_DEPTH-1){1'b0}}, 1'b1};

	state_t state_q, state_d;

	logic [TABLE_DEPTH-1:0] valid_w;
	logic [TABLE_DEPTH-1:0] hit_w;
	logic [TABLE_DEPTH-1:0] shift_vec;
	logic [TABLE_DEPTH-1:0] first_hit;
	logic [CH_W-1:0]        chan_w  [TABLE_DEPTH];
	logic [DA_W-1:0]        pitch_w [TABLE_DEPTH];
	cell_ctl_t              ctl;

	logic            accept;
	logic [CH_W-1:0] item_ch_q;
	logic [DA_W-1:0] item_a_q;

	logic            out_valid_q, out_valid_d;
	logic            out_type_q, out_type_d;
	logic [CH_W-1:0] out_channel_q, out_channel_d;
	logic [DA_W-1:0] out_data_a_q, out_data_a_d;
	logic [DB_W-1:0] out_data_b_q, out_data_b_d;
	logic            overflow_q, overflow_d;
	logic            last_q, last_d;

	assign busy      = (state_q != ST_IDLE);
	assign accept    = start && !busy;
	assign first_hit = hit_w & (~hit_w + ONE);

	for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
		logic            pv;
		logic            nv;
		logic [CH_W-1:0] nch;
		logic [DA_W-1:0] npi;
		if (i == 0) begin : g_head
			assign pv = 1'b1;
		end else begin : g_body
			assign pv = valid_w[i-1];
		end
		if (i == TABLE_DEPTH - 1) begin : g_tail
			assign nv  = 1'b0;
			assign nch = '0;
			assign npi = '0;
		end else begin : g_inner
			assign nv  = valid_w[i+1];
			assign nch = chan_w[i+1];
			assign npi = pitch_w[i+1];
		end
		ant_cell u_cell (
			.clk          (clk),
			.arst_n       (arst_n),
			.ctl          (ctl),
			.shift        (shift_vec[i]),
			.prev_valid   (pv),
			.next_valid   (nv),
			.next_channel (nch),
			.next_pitch   (npi),
			.valid        (valid_w[i]),
			.channel      (chan_w[i]),
			.pitch        (pitch_w[i]),
			.hit          (hit_w[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			out_valid_q <= out_valid_d;
		end
	end

	always_ff @(posedge clk) begin
		out_type_q    <= out_type_d;
		out_channel_q <= out_channel_d;
		out_data_a_q  <= out_data_a_d;
		out_data_b_q  <= out_data_b_d;
		overflow_q    <= overflow_d;
		last_q        <= last_d;
		if (accept) begin
			item_ch_q <= channel;
			item_a_q  <= data_a;
		end
	end

	always_comb begin
		state_d       = state_q;
		out_valid_d   = 1'b0;
		out_type_d    = out_type_q;
		out_channel_d = out_channel_q;
		out_data_a_d  = out_data_a_q;
		out_data_b_d  = out_data_b_q;
		overflow_d    = overflow_q;
		last_d        = last_q;
		ctl.append    = 1'b0;
		ctl.compare   = 1'b0;
		ctl.ch        = channel;
		ctl.pitch     = data_a;
		shift_vec     = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					if (kind == KIND_FLUSH) begin
						if (valid_w[0]) begin
							state_d = ST_FLUSH;
						end
					end else if (event_type == EV_CTRL) begin
						out_valid_d   = 1'b1;
						out_type_d    = OUT_CTRL;
						out_channel_d = channel;
						out_data_a_d  = data_a;
						out_data_b_d  = data_b;
						overflow_d    = 1'b0;
						last_d        = 1'b1;
					end else if (event_type == EV_NOTE) begin
						if (data_b != '0) begin
							if (!muted) begin
								ctl.append    = !valid_w[TABLE_DEPTH-1];
								out_valid_d   = 1'b1;
								out_type_d    = OUT_NOTE;
								out_channel_d = channel;
								out_data_a_d  = data_a;
								out_data_b_d  = data_b;
								overflow_d    = valid_w[TABLE_DEPTH-1];
								last_d        = 1'b1;
							end
						end else begin
							ctl.compare = 1'b1;
							state_d     = ST_REMOVE;
						end
					end
				end
			end
			ST_REMOVE: begin
				shift_vec = ~(first_hit - ONE);
				if (|hit_w) begin
					out_valid_d   = 1'b1;
					out_type_d    = OUT_NOTE;
					out_channel_d = item_ch_q;
					out_data_a_d  = item_a_q;
					out_data_b_d  = '0;
					overflow_d    = 1'b0;
					last_d        = 1'b1;
				end
				state_d = ST_IDLE;
			end
			ST_FLUSH: begin
				shift_vec     = '1;
				out_valid_d   = 1'b1;
				out_type_d    = OUT_NOTE;
				out_channel_d = chan_w[0];
				out_data_a_d  = pitch_w[0];
				out_data_b_d  = '0;
				overflow_d    = 1'b0;
				last_d        = !valid_w[1];
				if (!valid_w[1]) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	assign out_valid   = out_valid_q;
	assign out_type    = out_type_q;
	assign out_channel = out_channel_q;
	assign out_data_a  = out_data_a_q;
	assign out_data_b  = out_data_b_q;
	assign overflow    = overflow_q;
	assign last        = last_q;

	`ANT_ASSERT_SAME(a_valid_prefix, clk, arst_n, 1'b1, (valid_w & (valid_w + ONE)) == '0)
	`ANT_ASSERT_SAME(a_flush_nonempty, clk, arst_n, state_q == ST_FLUSH, valid_w[0])
	`ANT_ASSERT_NEXT(a_flush_emits, clk, arst_n, state_q == ST_FLUSH, out_valid)
	`ANT_ASSERT_NEXT(a_remove_one, clk, arst_n, (state_q == ST_REMOVE) && (|hit_w),
		$countones(valid_w) + 1 == $countones($past(valid_w)))
endmodule
`default_nettype wire
